### hw/rtl/opd_pkg.sv
// ----------------------------------------------------------------------------
// opd_pkg
// Shared types and constants for the Ogg page demultiplexer.
// ----------------------------------------------------------------------------
`default_nettype none

package opd_pkg;

   localparam int LACING_TABLE_DEPTH = 256;
   localparam int LACING_ADDR_W      = $clog2(LACING_TABLE_DEPTH);

   localparam logic [31:0] CAPTURE_PATTERN = 32'h4F676753;
   localparam logic [7:0]  FULL_LACING     = 8'd255;

   localparam logic [4:0] HDR_VERSION   = 5'd0;
   localparam logic [4:0] HDR_FLAGS     = 5'd1;
   localparam logic [4:0] HDR_GRAN_LAST = 5'd9;
   localparam logic [4:0] HDR_SER_LAST  = 5'd13;
   localparam logic [4:0] HDR_SEQ_LAST  = 5'd17;
   localparam logic [4:0] HDR_CRC_LAST  = 5'd21;
   localparam logic [4:0] HDR_SEGCOUNT  = 5'd22;

   localparam logic ACT_BYTE    = 1'b0;
   localparam logic ACT_RESTART = 1'b1;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_HEADER  = 1'b1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic       restart;
      logic [7:0] in_byte;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   typedef enum logic [5:0] {
      ST_HUNT       = 6'b000001,
      ST_HEADER     = 6'b000010,
      ST_LACING     = 6'b000100,
      ST_PAYLOAD    = 6'b001000,
      ST_SEEK_ADDR  = 6'b010000,
      ST_SEEK_CHECK = 6'b100000
   } state_type;

endpackage

`default_nettype wire

### hw/rtl/opd_ram.sv
// ----------------------------------------------------------------------------
// opd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module opd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

### hw/rtl/opd_front.sv
// ----------------------------------------------------------------------------
// opd_front
// Input side: accepts items, tags restarts, and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module opd_front
   import opd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_action,
   input  wire logic [7:0] req_in_byte,
   output queue_head_type  head,
   input  wire logic       pop
);

   item_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push;
   logic                do_pop;
   item_type            new_item;

   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign do_pop    = pop && (count_ff != '0);

   always_comb begin
      new_item.restart = (req_action == ACT_RESTART);
      new_item.in_byte = req_in_byte;
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/opd_back.sv
// ----------------------------------------------------------------------------
// opd_back
// Parser: capture hunt, header and lacing parse, payload marking, and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module opd_back
   import opd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  queue_head_type   head,
   output logic             pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_kind,
   output logic [7:0]       rsp_data_byte,
   output logic             rsp_packet_end,
   output logic [7:0]       rsp_version,
   output logic [7:0]       rsp_header_flags,
   output logic [63:0]      rsp_granule_position,
   output logic [31:0]      rsp_stream_serial,
   output logic [31:0]      rsp_page_sequence,
   output logic [31:0]      rsp_page_checksum,
   output logic [7:0]       rsp_segment_count,
   output logic [7:0]       rsp_packet_count
);

   state_type   state_ff, state_in;
   logic [31:0] window_ff, window_in;
   logic [4:0]  hidx_ff, hidx_in;
   logic [7:0]  total_ff, total_in;
   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  left_ff, left_in;
   logic [7:0]  segval_ff, segval_in;
   logic [7:0]  ver_ff, ver_in;
   logic [7:0]  flags_ff, flags_in;
   logic [63:0] gran_ff, gran_in;
   logic [31:0] ser_ff, ser_in;
   logic [31:0] seq_ff, seq_in;
   logic [31:0] crc_ff, crc_in;
   logic [7:0]  pkts_ff, pkts_in;

   logic        out_valid_ff, out_valid_in;
   logic        out_free;
   logic        emit_hdr, emit_pay, pay_end;
   logic [7:0]  b;
   logic [7:0]  ram_rdata;
   logic        ram_we;
   logic [7:0]  left_dec;
   logic [7:0]  hdr_total;
   logic [7:0]  hdr_pkts;

   assign b        = head.item.in_byte;
   assign out_free = !out_valid_ff || !rsp_stall;
   assign pop      = head.valid && out_free &&
                     (state_ff == ST_HUNT || state_ff == ST_HEADER ||
                      state_ff == ST_LACING || state_ff == ST_PAYLOAD);
   assign left_dec = left_ff - 8'd1;

   opd_ram #(
      .WIDTH (8),
      .DEPTH (LACING_TABLE_DEPTH)
   ) u_lacing (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (pos_ff[LACING_ADDR_W-1:0]),
      .wr_data (b),
      .rd_addr (pos_ff[LACING_ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in  = state_ff;
      window_in = window_ff;
      hidx_in   = hidx_ff;
      total_in  = total_ff;
      pos_in    = pos_ff;
      left_in   = left_ff;
      segval_in = segval_ff;
      ver_in    = ver_ff;
      flags_in  = flags_ff;
      gran_in   = gran_ff;
      ser_in    = ser_ff;
      seq_in    = seq_ff;
      crc_in    = crc_ff;
      pkts_in   = pkts_ff;
      emit_hdr  = 1'b0;
      emit_pay  = 1'b0;
      pay_end   = 1'b0;
      ram_we    = 1'b0;
      hdr_total = total_ff;
      hdr_pkts  = pkts_ff;

      if (pop && head.item.restart) begin
         state_in  = ST_HUNT;
         window_in = '0;
         hidx_in   = '0;
         total_in  = '0;
         pos_in    = '0;
         left_in   = '0;
         ver_in    = '0;
         flags_in  = '0;
         gran_in   = '0;
         ser_in    = '0;
         seq_in    = '0;
         crc_in    = '0;
         pkts_in   = '0;
      end else begin
         unique case (state_ff)
            ST_HUNT: begin
               if (pop) begin
                  window_in = {window_ff[23:0], b};
                  if ({window_ff[23:0], b} == CAPTURE_PATTERN) begin
                     window_in = '0;
                     hidx_in   = '0;
                     state_in  = ST_HEADER;
                  end
               end
            end
            ST_HEADER: begin
               if (pop) begin
                  hidx_in = hidx_ff + 5'd1;
                  if (hidx_ff == HDR_VERSION) begin
                     ver_in = b;
                  end else if (hidx_ff == HDR_FLAGS) begin
                     flags_in = b;
                  end else if (hidx_ff <= HDR_GRAN_LAST) begin
                     gran_in = {b, gran_ff[63:8]};
                  end else if (hidx_ff <= HDR_SER_LAST) begin
                     ser_in = {b, ser_ff[31:8]};
                  end else if (hidx_ff <= HDR_SEQ_LAST) begin
                     seq_in = {b, seq_ff[31:8]};
                  end else if (hidx_ff <= HDR_CRC_LAST) begin
                     crc_in = {b, crc_ff[31:8]};
                  end else begin
                     total_in  = b;
                     pos_in    = '0;
                     pkts_in   = '0;
                     hidx_in   = '0;
                     hdr_total = b;
                     hdr_pkts  = '0;
                     if (b == 8'd0) begin
                        emit_hdr = 1'b1;
                        state_in = ST_HUNT;
                     end else begin
                        state_in = ST_LACING;
                     end
                  end
               end
            end
            ST_LACING: begin
               if (pop) begin
                  ram_we = 1'b1;
                  if (b < FULL_LACING) begin
                     pkts_in = pkts_ff + 8'd1;
                  end
                  hdr_pkts = pkts_in;
                  pos_in   = pos_ff + 8'd1;
                  if ({1'b0, pos_ff} + 9'd1 >= {1'b0, total_ff}) begin
                     emit_hdr = 1'b1;
                     pos_in   = '0;
                     state_in = ST_SEEK_ADDR;
                  end
               end
            end
            ST_PAYLOAD: begin
               if (pop) begin
                  emit_pay = 1'b1;
                  left_in  = left_dec;
                  if (left_dec == 8'd0) begin
                     pay_end  = (segval_ff < FULL_LACING);
                     pos_in   = pos_ff + 8'd1;
                     state_in = ST_SEEK_ADDR;
                  end
               end
            end
            ST_SEEK_ADDR: begin
               // table read of pos_ff is in flight when we move on
               if (pos_ff < total_ff) begin
                  state_in = ST_SEEK_CHECK;
               end else begin
                  left_in  = '0;
                  state_in = ST_HUNT;
               end
            end
            ST_SEEK_CHECK: begin
               if (ram_rdata == 8'd0) begin
                  pos_in   = pos_ff + 8'd1;
                  state_in = ST_SEEK_ADDR;
               end else begin
                  left_in   = ram_rdata;
                  segval_in = ram_rdata;
                  state_in  = ST_PAYLOAD;
               end
            end
            default: begin
               state_in = ST_HUNT;
            end
         endcase
      end

      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = emit_hdr || emit_pay;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_HUNT;
         window_ff    <= '0;
         hidx_ff      <= '0;
         total_ff     <= '0;
         pos_ff       <= '0;
         left_ff      <= '0;
         pkts_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         hidx_ff      <= hidx_in;
         total_ff     <= total_in;
         pos_ff       <= pos_in;
         left_ff      <= left_in;
         pkts_ff      <= pkts_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      segval_ff <= segval_in;
      ver_ff    <= ver_in;
      flags_ff  <= flags_in;
      gran_ff   <= gran_in;
      ser_ff    <= ser_in;
      seq_ff    <= seq_in;
      crc_ff    <= crc_in;
      if (emit_hdr) begin
         rsp_kind             <= KIND_HEADER;
         rsp_data_byte        <= '0;
         rsp_packet_end       <= 1'b0;
         rsp_version          <= ver_in;
         rsp_header_flags     <= flags_in;
         rsp_granule_position <= gran_in;
         rsp_stream_serial    <= ser_in;
         rsp_page_sequence    <= seq_in;
         rsp_page_checksum    <= crc_in;
         rsp_segment_count    <= hdr_total;
         rsp_packet_count     <= hdr_pkts;
      end else if (emit_pay) begin
         rsp_kind             <= KIND_PAYLOAD;
         rsp_data_byte        <= b;
         rsp_packet_end       <= pay_end;
         rsp_version          <= '0;
         rsp_header_flags     <= '0;
         rsp_granule_position <= '0;
         rsp_stream_serial    <= '0;
         rsp_page_sequence    <= '0;
         rsp_page_checksum    <= '0;
         rsp_segment_count    <= '0;
         rsp_packet_count     <= '0;
      end
   end

   assign rsp_valid = out_valid_ff;

   a_no_pop_in_seek: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEEK_ADDR || state_ff == ST_SEEK_CHECK) |-> !pop)
      else $error("item taken during lacing seek");

   a_payload_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAYLOAD) |-> (left_ff != 8'd0 && pos_ff < total_ff))
      else $error("payload state with empty segment");

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      (emit_hdr || emit_pay) |-> out_free)
      else $error("result produced while output register full");

   a_ram_write_lacing: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_LACING))
      else $error("lacing table written outside lacing parse");

endmodule

`default_nettype wire

### hw/rtl/ogg_page_packet_demux_top.sv
// ----------------------------------------------------------------------------
// ogg_page_packet_demux_top
// Ogg page demultiplexer: hunts for the capture pattern, parses the page
// header and lacing table, then passes payload bytes with packet ends marked.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake              payload
//   req_      in    req_valid / req_stall  action, in_byte
//   rsp_      out   rsp_valid / rsp_stall  kind, data_byte, packet_end, header fields
//
// Cycles: one stream byte per cycle while hunting, parsing the header or
// lacing table, and moving payload, if an item waits and the result register
// is free. After the header result and after each segment the parser walks
// the lacing RAM (registered read), an address and a check state per entry.
// Reset: synchronous, active high; the queue empties and the parser hunts.
// Stalls: a 2-entry queue keeps taking input while the result register waits
// on rsp_stall; req_stall rises only when that queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module ogg_page_packet_demux_top
   import opd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_action,
   input  wire logic [7:0]  req_in_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_kind,
   output logic [7:0]       rsp_data_byte,
   output logic             rsp_packet_end,
   output logic [7:0]       rsp_version,
   output logic [7:0]       rsp_header_flags,
   output logic [63:0]      rsp_granule_position,
   output logic [31:0]      rsp_stream_serial,
   output logic [31:0]      rsp_page_sequence,
   output logic [31:0]      rsp_page_checksum,
   output logic [7:0]       rsp_segment_count,
   output logic [7:0]       rsp_packet_count
);

   queue_head_type head;
   logic           pop;

   // front: take items and hold them until the parser is ready
   opd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_action  (req_action),
      .req_in_byte (req_in_byte),
      .head        (head),
      .pop         (pop)
   );

   // back: parse, walk the lacing table, drive the result register
   opd_back u_back (
      .clock                (clock),
      .reset                (reset),
      .head                 (head),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_kind             (rsp_kind),
      .rsp_data_byte        (rsp_data_byte),
      .rsp_packet_end       (rsp_packet_end),
      .rsp_version          (rsp_version),
      .rsp_header_flags     (rsp_header_flags),
      .rsp_granule_position (rsp_granule_position),
      .rsp_stream_serial    (rsp_stream_serial),
      .rsp_page_sequence    (rsp_page_sequence),
      .rsp_page_checksum    (rsp_page_checksum),
      .rsp_segment_count    (rsp_segment_count),
      .rsp_packet_count     (rsp_packet_count)
   );

endmodule

`default_nettype wire
